// ===== hdl/vend_pkg.sv =====
// Package: shared types and constants of the vending controller.
`default_nettype none

package vend_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned AMOUNT_W   = 10;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned PRICE_W    = 16;
  localparam int unsigned QTY_W      = 8;
  localparam int unsigned BAL_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned KIND_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_COIN     = 2'd0,
    KIND_SELECT   = 2'd1,
    KIND_LOAD     = 2'd2,
    KIND_DISPENSE = 2'd3
  } vend_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_COIN_TAKEN       = 3'd0,
    STAT_PAY_FIRST        = 3'd1,
    STAT_NO_STOCK         = 3'd2,
    STAT_SHORT_MONEY      = 3'd3,
    STAT_DISPENSED        = 3'd4,
    STAT_SELECT_FIRST     = 3'd5,
    STAT_PAY_SELECT_FIRST = 3'd6,
    STAT_LOADED           = 3'd7
  } vend_status_e;

  typedef enum logic {
    MODE_IDLE      = 1'b0,
    MODE_HAS_MONEY = 1'b1
  } vend_mode_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } vend_state_e;

  typedef struct packed {
    vend_kind_e          kind;
    logic [AMOUNT_W-1:0] amount;
    logic [SLOT_W-1:0]   slot;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    quantity;
  } vend_item_t;

  typedef struct packed {
    vend_status_e       status;
    logic [BAL_W-1:0]   balance_now;
    logic [BAL_W-1:0]   change;
    logic [SLOT_W-1:0]  dispensed_slot;
    vend_mode_e         mode_now;
  } vend_res_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   stock;
  } vend_entry_t;

endpackage

`default_nettype wire

// ===== hdl/vend_ifs.sv =====
// Interfaces: input item channel and result channel of the vending controller.
`default_nettype none

interface vend_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  amount;
  logic [7:0]  slot;
  logic [15:0] price;
  logic [7:0]  quantity;

  modport source (output valid, kind, amount, slot, price, quantity, input ready);
  modport sink   (input valid, kind, amount, slot, price, quantity, output ready);
endinterface

interface vend_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] balance_now;
  logic [15:0] change;
  logic [7:0]  dispensed_slot;
  logic        mode_now;

  modport source (output valid, status, balance_now, change, dispensed_slot, mode_now,
                  input ready);
  modport sink   (input valid, status, balance_now, change, dispensed_slot, mode_now,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/vend_slot_mem.sv =====
// Slot table: price and stock per slot, one write and one registered read port.
`default_nettype none

module vend_slot_mem #(
  parameter int unsigned SLOTS = vend_pkg::SLOTS_DEF,
  parameter int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output      vend_pkg::vend_entry_t rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire vend_pkg::vend_entry_t wr_data_i
);
  import vend_pkg::*;

  vend_entry_t            mem [SLOTS];
  logic [SLOTS-1:0]       vld_q;
  vend_entry_t            rdata_q;
  logic                   rvld_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Per-entry valid bits: an entry never loaded reads as empty stock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Mask stock of unloaded entries; price of such entries is never used
  always_comb begin
    rd_data_o.price = rdata_q.price;
    rd_data_o.stock = rvld_q ? rdata_q.stock : '0;
  end

endmodule

`default_nettype wire

// ===== hdl/vend_exec.sv =====
// Item execution: decides the result and the slot write-back for one item.
`default_nettype none

module vend_exec #(
  parameter int unsigned SLOTS = vend_pkg::SLOTS_DEF
) (
  input  wire vend_pkg::vend_item_t  item_i,
  input  wire vend_pkg::vend_mode_e  mode_i,
  input  wire logic [15:0]           balance_i,
  input  wire vend_pkg::vend_entry_t entry_i,
  output      vend_pkg::vend_res_t   res_o,
  output      vend_pkg::vend_mode_e  mode_o,
  output      logic [15:0]           balance_o,
  output      logic                  wr_en_o,
  output      vend_pkg::vend_entry_t wr_data_o
);
  import vend_pkg::*;

  logic             in_range;
  logic [BAL_W:0]   coin_sum;

  assign in_range = ({1'b0, item_i.slot} < (SLOT_W + 1)'(SLOTS));
  assign coin_sum = {1'b0, balance_i} + (BAL_W + 1)'(item_i.amount);

  // Decode the item against current mode, balance and slot entry
  always_comb begin
    res_o.status         = STAT_COIN_TAKEN;
    res_o.change         = '0;
    res_o.dispensed_slot = '0;
    mode_o               = mode_i;
    balance_o            = balance_i;
    wr_en_o              = 1'b0;
    wr_data_o            = entry_i;
    case (item_i.kind)
      KIND_COIN: begin
        balance_o    = coin_sum[BAL_W] ? '1 : coin_sum[BAL_W-1:0];
        mode_o       = MODE_HAS_MONEY;
        res_o.status = STAT_COIN_TAKEN;
      end
      KIND_SELECT: begin
        if (mode_i == MODE_IDLE) begin
          res_o.status = STAT_PAY_FIRST;
        end else if (!in_range || entry_i.stock == '0) begin
          res_o.status = STAT_NO_STOCK;
        end else if (balance_i < entry_i.price) begin
          res_o.status = STAT_SHORT_MONEY;
        end else begin
          wr_en_o              = 1'b1;
          wr_data_o.stock      = entry_i.stock - QTY_W'(1);
          res_o.change         = balance_i - entry_i.price;
          res_o.dispensed_slot = item_i.slot;
          balance_o            = '0;
          mode_o               = MODE_IDLE;
          res_o.status         = STAT_DISPENSED;
        end
      end
      KIND_LOAD: begin
        wr_en_o         = in_range;
        wr_data_o.price = item_i.price;
        wr_data_o.stock = item_i.quantity;
        res_o.status    = STAT_LOADED;
      end
      KIND_DISPENSE: begin
        res_o.status = (mode_i == MODE_IDLE) ? STAT_PAY_SELECT_FIRST : STAT_SELECT_FIRST;
      end
      default: begin
        res_o.status = STAT_SELECT_FIRST;
      end
    endcase
    res_o.balance_now = balance_o;
    res_o.mode_now    = mode_o;
  end

endmodule

`default_nettype wire

// ===== hdl/vending_controller.sv =====
// Top level: vending controller with slot table in memory and result register.
//
//   channel | dir | payload                                           | handshake
//   in_i    | in  | kind, amount, slot, price, quantity               | valid/ready
//   out_o   | out | status, balance_now, change, dispensed_slot, mode | valid/ready
//
// For each item, the accept edge reads the slot table; the commit edge, once out_o
// has room, decides the result, writes the entry back and loads the result register.
// The registered table read and the read-modify-write of one entry set that order.
// A new item is taken only after the previous write-back, so no forwarding.
// Reset clears mode, balance and all slot stock at once; no clearing pass.
// A stalled result holds the item in its decide cycle until out_o has room.
`default_nettype none

module vending_controller #(
  parameter int unsigned SLOTS = vend_pkg::SLOTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vend_in_if.sink    in_i,
  vend_out_if.source out_o
);
  import vend_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  vend_state_e  state_q, state_d;
  vend_item_t   item_q;
  vend_mode_e   mode_q, mode_d;
  logic [15:0]  balance_q, balance_d;
  logic         out_valid_q;
  vend_res_t    res_q, res_d;
  vend_entry_t  rd_entry;
  vend_entry_t  wr_entry;
  logic         exec_wr_en;
  logic         wr_en;
  logic         in_fire;
  logic         commit;

  assign in_fire = in_i.valid && in_i.ready;
  assign commit  = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign wr_en   = commit && exec_wr_en;

  // Slot table
  vend_slot_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_i.slot[AW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (item_q.slot[AW-1:0]),
    .wr_data_i (wr_entry)
  );

  // Item decode
  vend_exec #(
    .SLOTS (SLOTS)
  ) u_exec (
    .item_i    (item_q),
    .mode_i    (mode_q),
    .balance_i (balance_q),
    .entry_i   (rd_entry),
    .res_o     (res_d),
    .mode_o    (mode_d),
    .balance_o (balance_d),
    .wr_en_o   (exec_wr_en),
    .wr_data_o (wr_entry)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_i.ready = 1'b0;
    case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_EXEC:  in_i.ready = 1'b0;
      default: in_i.ready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      balance_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        mode_q      <= mode_d;
        balance_q   <= balance_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.kind     <= vend_kind_e'(in_i.kind);
      item_q.amount   <= in_i.amount;
      item_q.slot     <= in_i.slot;
      item_q.price    <= in_i.price;
      item_q.quantity <= in_i.quantity;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.balance_now    = res_q.balance_now;
  assign out_o.change         = res_q.change;
  assign out_o.dispensed_slot = res_q.dispensed_slot;
  assign out_o.mode_now       = res_q.mode_now;

  // Idle mode always carries a zero balance
  a_idle_zero_bal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (balance_q == '0))
    else $error("balance nonzero in idle mode");

  // A dispense leaves the machine idle with nothing owed
  a_disp_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == STAT_DISPENSED) |->
      (res_q.mode_now == MODE_IDLE && res_q.balance_now == '0))
    else $error("dispense did not clear balance and mode");

  // Table writes only happen while an item commits
  a_wr_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_EXEC && commit))
    else $error("slot table written outside commit");

  // No new item is taken in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("item accepted during read-modify-write");

endmodule

`default_nettype wire

// ===== tb/vending_controller_test.sv =====
// Testbench: vending controller checked against a behavioral prediction of the machine.
`timescale 1ns / 1ps

module vending_controller_test;
  import vend_pkg::*;

  localparam int unsigned SLOT_COUNT    = SLOTS_DEF;
  localparam int unsigned ITEM_TARGET   = 1450;
  localparam int unsigned CALM_ITEMS    = 150;
  localparam int unsigned TAIL_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned DIRECTED_ROWS = 25;

  typedef struct packed {
    vend_item_t item;
    logic       typed;
    vend_res_t  res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vend_in_if  in_ch ();
  vend_out_if out_ch ();

  vending_controller #(
    .SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Machine state as the predictor sees it
  vend_mode_e         till_mode    = MODE_IDLE;
  logic [BAL_W-1:0]   till_balance = '0;
  logic [PRICE_W-1:0] shelf_price [SLOT_COUNT] = '{default: '0};
  logic [QTY_W-1:0]   shelf_stock [SLOT_COUNT] = '{default: '0};

  vend_res_t   pending_receipts [$];
  vend_res_t   oldest_receipt;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;

  // Directed opening: typed results only where they are obvious
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // select and dispense request right after reset
    '{'{KIND_SELECT, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_PAY_FIRST, 16'd0, 16'd0, 8'd0, MODE_IDLE}},
    '{'{KIND_DISPENSE, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_PAY_SELECT_FIRST, 16'd0, 16'd0, 8'd0, MODE_IDLE}},
    // load while idle, free item in slot 0
    '{'{KIND_LOAD, 10'd0, 8'd0, 16'h0000, 8'd1}, 1'b1,
      '{STAT_LOADED, 16'd0, 16'd0, 8'd0, MODE_IDLE}},
    // zero coin still enters has-money mode
    '{'{KIND_COIN, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_COIN_TAKEN, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_DISPENSE, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_SELECT_FIRST, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    // empty slot and slot codes past the table
    '{'{KIND_SELECT, 10'd0, 8'd3, 16'h0000, 8'd0}, 1'b1,
      '{STAT_NO_STOCK, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_SELECT, 10'd0, 8'd16, 16'h0000, 8'd0}, 1'b1,
      '{STAT_NO_STOCK, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_SELECT, 10'd0, 8'd255, 16'h0000, 8'd0}, 1'b1,
      '{STAT_NO_STOCK, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_LOAD, 10'd0, 8'd255, 16'hFFFF, 8'd255}, 1'b1,
      '{STAT_LOADED, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    // most expensive and fullest slot
    '{'{KIND_LOAD, 10'd0, 8'd15, 16'hFFFF, 8'd255}, 1'b1,
      '{STAT_LOADED, 16'd0, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_COIN, 10'd1023, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_COIN_TAKEN, 16'd1023, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_SELECT, 10'd0, 8'd15, 16'h0000, 8'd0}, 1'b1,
      '{STAT_SHORT_MONEY, 16'd1023, 16'd0, 8'd0, MODE_HAS_MONEY}},
    '{'{KIND_SELECT, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b1,
      '{STAT_DISPENSED, 16'd0, 16'd1023, 8'd0, MODE_IDLE}},
    // slot 0 sold out, then a purchase from slot 7 that returns one in change
    '{'{KIND_COIN, 10'd1, 8'd0, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_SELECT, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_LOAD, 10'd0, 8'd7, 16'd1000, 8'd2}, 1'b0, '0},
    '{'{KIND_COIN, 10'd512, 8'd0, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_SELECT, 10'd0, 8'd7, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_COIN, 10'd488, 8'd0, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_SELECT, 10'd0, 8'd7, 16'h0000, 8'd0}, 1'b0, '0},
    // emptying load in has-money mode
    '{'{KIND_COIN, 10'h2AA, 8'd0, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_LOAD, 10'h155, 8'd7, 16'h5555, 8'd0}, 1'b0, '0},
    '{'{KIND_SELECT, 10'd0, 8'd7, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_SELECT, 10'd0, 8'd15, 16'h0000, 8'd0}, 1'b0, '0},
    '{'{KIND_DISPENSE, 10'd0, 8'd0, 16'h0000, 8'd0}, 1'b0, '0}
  };

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out the receipt of one item and advance the machine state
  function automatic vend_res_t vend_outcome(input vend_item_t it);
    vend_res_t        r;
    logic [BAL_W:0]   sum;
    int unsigned      idx;
    r   = '0;
    idx = it.slot;
    case (it.kind)
      KIND_COIN: begin
        sum          = {1'b0, till_balance} + (BAL_W+1)'(it.amount);
        till_balance = sum[BAL_W] ? '1 : sum[BAL_W-1:0];
        till_mode    = MODE_HAS_MONEY;
        r.status     = STAT_COIN_TAKEN;
      end
      KIND_SELECT: begin
        if (till_mode == MODE_IDLE) begin
          r.status = STAT_PAY_FIRST;
        end else if (idx >= SLOT_COUNT || shelf_stock[idx] == '0) begin
          r.status = STAT_NO_STOCK;
        end else if (till_balance < shelf_price[idx]) begin
          r.status = STAT_SHORT_MONEY;
        end else begin
          shelf_stock[idx]  = shelf_stock[idx] - 1'b1;
          r.change          = till_balance - shelf_price[idx];
          r.dispensed_slot  = it.slot;
          till_balance      = '0;
          till_mode         = MODE_IDLE;
          r.status          = STAT_DISPENSED;
        end
      end
      KIND_LOAD: begin
        if (idx < SLOT_COUNT) begin
          shelf_price[idx] = it.price;
          shelf_stock[idx] = it.quantity;
        end
        r.status = STAT_LOADED;
      end
      default: begin
        r.status = (till_mode == MODE_IDLE) ? STAT_PAY_SELECT_FIRST : STAT_SELECT_FIRST;
      end
    endcase
    r.balance_now = till_balance;
    r.mode_now    = till_mode;
    return r;
  endfunction

  function automatic vend_item_t random_item();
    vend_item_t it;
    it.kind     = vend_kind_e'($urandom_range(0, 3));
    it.amount   = AMOUNT_W'($urandom());
    it.slot     = SLOT_W'($urandom());
    it.price    = PRICE_W'($urandom());
    it.quantity = QTY_W'($urandom());
    return it;
  endfunction

  // Present one item, hold it until taken, and queue its receipt
  task automatic offer_item(input vend_item_t it, input logic typed, input vend_res_t typed_res);
    vend_res_t outcome;
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= it.kind;
    in_ch.amount   <= it.amount;
    in_ch.slot     <= it.slot;
    in_ch.price    <= it.price;
    in_ch.quantity <= it.quantity;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    outcome = vend_outcome(it);
    pending_receipts.push_back(typed ? typed_res : outcome);
    items_sent++;
  endtask

  task automatic offer(input vend_item_t it);
    offer_item(it, 1'b0, '0);
  endtask

  // Stop sending and wait for every outstanding receipt
  task automatic wait_for_receipts();
    if (pending_receipts.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (pending_receipts.size() != 0) @(posedge clk_i);
    end
  endtask

  // Coins, maybe a stray dispense request, then a select; if refused, maybe retry once with a coin
  task automatic run_purchase();
    vend_item_t it;
    repeat ($urandom_range(1, 4)) begin
      it      = random_item();
      it.kind = KIND_COIN;
      if ($urandom_range(0, 5) == 0) it.amount = '1;
      offer(it);
    end
    if ($urandom_range(0, 7) == 0) begin
      it      = random_item();
      it.kind = KIND_DISPENSE;
      offer(it);
    end
    it      = random_item();
    it.kind = KIND_SELECT;
    if ($urandom_range(0, 6) != 0) it.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    offer(it);
    if (till_mode == MODE_HAS_MONEY && $urandom_range(0, 1) == 1) begin
      it.kind   = KIND_COIN;
      it.amount = AMOUNT_W'($urandom());
      offer(it);
      it.kind = KIND_SELECT;
      offer(it);
    end
  endtask

  // Refill a few slots, mostly cheap and nearly empty
  task automatic run_restock();
    vend_item_t it;
    repeat ($urandom_range(1, 3)) begin
      it      = random_item();
      it.kind = KIND_LOAD;
      if ($urandom_range(0, 9) != 0) it.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      if ($urandom_range(0, 4) != 0) it.price = PRICE_W'($urandom_range(0, 2500));
      if ($urandom_range(0, 4) != 0) it.quantity = QTY_W'($urandom_range(0, 4));
      offer(it);
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 3)) offer(random_item());
  endtask

  // Drive the balance into saturation, then try to spend it
  task automatic run_hoard();
    vend_item_t it;
    wait_for_receipts();
    repeat (66 + $urandom_range(0, 3)) begin
      it        = random_item();
      it.kind   = KIND_COIN;
      it.amount = '1;
      offer(it);
    end
    it      = random_item();
    it.kind = KIND_SELECT;
    it.slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    offer(it);
  endtask

  // Result side: random stall bursts, none near the end
  initial begin
    int unsigned hold_off;
    hold_off = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off != 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_off = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      mismatch_count++;
    end
  endtask

  // Compare every accepted receipt with the oldest one expected
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_receipts.size() == 0) begin
        $error("receipt: none expected, got status %0d", out_ch.status);
        mismatch_count++;
      end else begin
        oldest_receipt = pending_receipts.pop_front();
        check_field("status", oldest_receipt.status, out_ch.status);
        check_field("balance_now", oldest_receipt.balance_now, out_ch.balance_now);
        check_field("change", oldest_receipt.change, out_ch.change);
        check_field("dispensed_slot", oldest_receipt.dispensed_slot, out_ch.dispensed_slot);
        check_field("mode_now", oldest_receipt.mode_now, out_ch.mode_now);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned seq_no;
    int unsigned pick;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= '0;
    in_ch.amount   <= '0;
    in_ch.slot     <= '0;
    in_ch.price    <= '0;
    in_ch.quantity <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    end

    // Mostly well-formed customer sessions with some noise in between
    seq_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (seq_no == 3 || pick == 0) begin
        run_hoard();
      end else if (pick < 56) begin
        run_purchase();
      end else if (pick < 78) begin
        run_restock();
      end else begin
        run_noise();
      end
      if (seq_no == 150) wait_for_receipts();
      seq_no++;
    end

    wait_for_receipts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
